FILE: hdl/shamh_pkg.sv
// Shared constants for the SHA-256 message hasher: working-variable type,
// initial hash values and the round constant table. No dependencies.
package shamh_pkg;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
	} shamh_vars_t;

	localparam int unsigned HASH_WORDS = 8;
	localparam int unsigned ROUNDS = 64;

	localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

FILE: hdl/shamh_round.sv
// One SHA-256 compression round plus the next message schedule word.
// Uses shamh_pkg for the working-variable type.
module shamh_round (
	input  shamh_pkg::shamh_vars_t v,
	input  logic [31:0]            k,
	input  logic [31:0]            w0,
	input  logic [31:0]            w1,
	input  logic [31:0]            w9,
	input  logic [31:0]            w14,
	output shamh_pkg::shamh_vars_t v_next,
	output logic [31:0]            w_next
);

	logic [31:0] big_s0;
	logic [31:0] big_s1;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] sm_s0;
	logic [31:0] sm_s1;

	always_comb begin
		big_s1 = {v.e[5:0], v.e[31:6]} ^ {v.e[10:0], v.e[31:11]} ^ {v.e[24:0], v.e[31:25]};
		big_s0 = {v.a[1:0], v.a[31:2]} ^ {v.a[12:0], v.a[31:13]} ^ {v.a[21:0], v.a[31:22]};
		ch     = (v.e & v.f) ^ (~v.e & v.g);
		maj    = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
		t1     = v.h + big_s1 + ch + k + w0;
		t2     = big_s0 + maj;

		v_next.a = t1 + t2;
		v_next.b = v.a;
		v_next.c = v.b;
		v_next.d = v.c;
		v_next.e = v.d + t1;
		v_next.f = v.e;
		v_next.g = v.f;
		v_next.h = v.g;

		sm_s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
		sm_s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
		w_next = sm_s1 + w9 + sm_s0 + w0;
	end

endmodule

FILE: hdl/sha256_message_hasher_core.sv
// SHA-256 hasher over a byte stream. Bytes are accepted while idle; the 64th byte of a
// block starts 64 rounds through one shared round unit, then the chain add. After the
// end transfer, padding inserts one byte a cycle (64-p or 128-p bytes for p bytes in the
// open block), compressing each filled block, then eight digest words follow, one per
// cycle while m_tready is set. Input is not ready during compression, padding or output.
// Reset (arst_n low) loads the initial hash, clears the byte count and returns to idle.
module sha256_message_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_tuser,  // [0] byte_present
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast   // last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_FOLD  = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [5:0]  FILL_LAST = 6'd63;
	localparam logic [5:0]  FILL_LEN  = 6'd56;
	localparam logic [5:0]  ROUND_LAST = 6'd63;
	localparam logic [2:0]  WORD_LAST = 3'd7;
	localparam logic [60:0] COUNT_MAX = '1;
	localparam logic [7:0]  PAD_MARK = 8'h80;

	logic [2:0]   state_q;
	logic [511:0] msg_q;
	logic [5:0]   fill_q;
	logic [60:0]  cnt_q;
	logic [5:0]   rnd_q;
	logic         end_q;
	logic         sent80_q;
	logic         lenblk_q;
	logic [2:0]   idx_q;
	logic [31:0]  chain_q [shamh_pkg::HASH_WORDS];
	shamh_pkg::shamh_vars_t wv_q;

	shamh_pkg::shamh_vars_t v_next;
	shamh_pkg::shamh_vars_t chain_vars;
	logic [31:0] w_next;
	logic        in_xfer;
	logic        ins_en;
	logic [7:0]  ins_byte;
	logic [7:0]  pad_byte;
	logic [7:0]  len_byte;
	logic [63:0] len_bits;
	logic        blk_full;

	shamh_round u_round (
		.v      (wv_q),
		.k      (shamh_pkg::ROUND_K[rnd_q]),
		.w0     (msg_q[511:480]),
		.w1     (msg_q[479:448]),
		.w9     (msg_q[223:192]),
		.w14    (msg_q[63:32]),
		.v_next (v_next),
		.w_next (w_next)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'b00000, idx_q, chain_q[0]};
	assign m_tlast  = (idx_q == WORD_LAST);
	assign in_xfer  = s_tvalid && s_tready;

	always_comb begin
		len_bits = {cnt_q, 3'b000};
		len_byte = len_bits[{3'd7 - fill_q[2:0], 3'b000} +: 8];
		priority if (!sent80_q) begin
			pad_byte = PAD_MARK;
		end else if (lenblk_q && (fill_q >= FILL_LEN)) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
		ins_en   = (in_xfer && s_tuser[0]) || (state_q == ST_PAD);
		ins_byte = (state_q == ST_PAD) ? pad_byte : s_tdata;
		blk_full = ins_en && (fill_q == FILL_LAST);
		chain_vars = {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
			chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			cnt_q    <= '0;
			rnd_q    <= '0;
			end_q    <= 1'b0;
			sent80_q <= 1'b0;
			lenblk_q <= 1'b0;
			idx_q    <= '0;
			chain_q  <= shamh_pkg::INIT_HASH;
		end else begin
			if (ins_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (blk_full) begin
				rnd_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						end_q <= s_tlast;
						if (s_tuser[0] && (cnt_q != COUNT_MAX)) begin
							cnt_q <= cnt_q + 61'd1;
						end
						priority if (blk_full) begin
							state_q <= ST_ROUND;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					if (!sent80_q) begin
						sent80_q <= 1'b1;
						// length fits behind the mark in this block
						if (fill_q < FILL_LEN) begin
							lenblk_q <= 1'b1;
						end
					end
					if (blk_full) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == ROUND_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					chain_q[0] <= chain_q[0] + wv_q.a;
					chain_q[1] <= chain_q[1] + wv_q.b;
					chain_q[2] <= chain_q[2] + wv_q.c;
					chain_q[3] <= chain_q[3] + wv_q.d;
					chain_q[4] <= chain_q[4] + wv_q.e;
					chain_q[5] <= chain_q[5] + wv_q.f;
					chain_q[6] <= chain_q[6] + wv_q.g;
					chain_q[7] <= chain_q[7] + wv_q.h;
					priority if (end_q && sent80_q && lenblk_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (end_q) begin
						// mark went into a block too full for the length: next block is final
						if (sent80_q) begin
							lenblk_q <= 1'b1;
						end
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == WORD_LAST) begin
							chain_q  <= shamh_pkg::INIT_HASH;
							cnt_q    <= '0;
							fill_q   <= '0;
							end_q    <= 1'b0;
							sent80_q <= 1'b0;
							lenblk_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							// rotate the next digest word into the output slot
							for (int i = 0; i < 7; i++) begin
								chain_q[i] <= chain_q[i + 1];
							end
							chain_q[7] <= chain_q[0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// message window and working variables, no reset needed
	always_ff @(posedge clk) begin
		if (ins_en) begin
			msg_q <= {msg_q[503:0], ins_byte};
		end else if (state_q == ST_ROUND) begin
			msg_q <= {msg_q[479:0], w_next};
		end
		if (blk_full) begin
			wv_q <= chain_vars;
		end else if (state_q == ST_ROUND) begin
			wv_q <= v_next;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest output is pending");

	a_fold_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> ($past(state_q) == ST_ROUND && $past(rnd_q) == ROUND_LAST))
		else $error("chain add not preceded by the last round");

	a_idle_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_q == '0 && cnt_q == '0))
		else $error("not back to idle after the final digest word");

	a_out_needs_padding: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (end_q && sent80_q && lenblk_q && fill_q == '0))
		else $error("digest output without completed padding");

endmodule

FILE: tb/sha256_message_hasher_core_tb.sv
// Self-checking bench for sha256_message_hasher_core: byte-stream messages in, digest words out.
// Carries its own SHA-256 model and constant tables; needs only the core RTL, shamh_round and shamh_pkg.
module sha256_message_hasher_core_tb;

	typedef struct packed {
		logic [7:0]   data;
		logic         present;
		logic         eom;
		logic         typed;
		logic [255:0] digest;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        is_last;
	} digest_word_t;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 300;
	localparam int STEADY_LEN = 120;

	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// data, byte_present, end_of_message, digest typed in, digest
	localparam msg_item_t DIRECTED_ITEMS [12] = '{
		{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
		{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
		{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
		{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'h5a, 1'b0, 1'b1, 1'b0, 256'h0},
		{8'ha5, 1'b1, 1'b1, 1'b0, 256'h0},
		{8'h00, 1'b1, 1'b1, 1'b0, 256'h0}
	};

	// lengths around the one-block/two-block padding split and full blocks
	localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	logic        steady;
	int          errors = 0;
	int          quiet_cycles = 0;

	logic [31:0] hash_block [16];
	logic [31:0] hash_chain [8];
	logic [60:0] hash_nbytes;
	int          hash_fill;

	digest_word_t pending_words [$];

	sha256_message_hasher_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] wt, s0, s1, t1, t2;
		a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
		e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = hash_block[t];
			end else begin
				s0 = rotr32(w[(t - 15) % 16], 7) ^ rotr32(w[(t - 15) % 16], 18)
					^ (w[(t - 15) % 16] >> 3);
				s1 = rotr32(w[(t - 2) % 16], 17) ^ rotr32(w[(t - 2) % 16], 19)
					^ (w[(t - 2) % 16] >> 10);
				wt = s1 + w[(t - 7) % 16] + s0 + w[t % 16];
			end
			w[t % 16] = wt;
			t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_CONST[t] + wt;
			t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
		hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
	endfunction

	function automatic void hash_put_byte(input logic [7:0] b);
		if (hash_fill % 4 == 0)
			hash_block[hash_fill / 4] = {b, 24'h0};
		else
			hash_block[hash_fill / 4][8 * (3 - hash_fill % 4) +: 8] = b;
		hash_fill++;
		if (hash_fill == 64) begin
			hash_compress();
			hash_fill = 0;
		end
	endfunction

	function automatic void hash_restart();
		for (int i = 0; i < 8; i++)
			hash_chain[i] = HASH_INIT[i];
		hash_nbytes = '0;
		hash_fill = 0;
	endfunction

	// Returns 1 when the item closes a message; digest holds H0 in its top word.
	function automatic bit hash_item(input logic [7:0] d, input logic p, input logic l,
			output logic [255:0] digest);
		digest = '0;
		if (p) begin
			hash_put_byte(d);
			if (hash_nbytes != '1)
				hash_nbytes++;
		end
		if (!l)
			return 1'b0;
		if (hash_fill % 4 == 0)
			hash_block[hash_fill / 4] = 32'h8000_0000;
		else
			hash_block[hash_fill / 4][8 * (3 - hash_fill % 4) +: 8] = 8'h80;
		for (int i = hash_fill / 4 + 1; i < 16; i++)
			hash_block[i] = '0;
		// no room for the length: close this block and pad a second one
		if (hash_fill >= 56) begin
			hash_compress();
			for (int i = 0; i < 16; i++)
				hash_block[i] = '0;
		end
		{hash_block[14], hash_block[15]} = {hash_nbytes, 3'b000};
		hash_compress();
		for (int i = 0; i < 8; i++)
			digest[255 - 32 * i -: 32] = hash_chain[i];
		hash_restart();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic [7:0] d, input logic p, input logic l,
			input bit typed, input logic [255:0] typed_digest);
		logic [255:0] digest;
		digest_word_t dw;
		while (!steady && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= p;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (hash_item(d, p, l, digest)) begin
			if (typed)
				digest = typed_digest;
			for (int i = 0; i < 8; i++) begin
				dw.word = digest[255 - 32 * i -: 32];
				dw.index = 3'(i);
				dw.is_last = (i == 7);
				pending_words.push_back(dw);
			end
		end
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// Output side: random backpressure, digest checks and the no-progress watchdog.
	always @(posedge clk) begin
		digest_word_t want;
		m_tready <= steady || ($urandom_range(99) >= 26);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected digest_word", m_tdata[31:0], 32'h0);
			end else begin
				want = pending_words.pop_front();
				if (m_tdata[31:0] !== want.word)
					report_mismatch("digest_word", m_tdata[31:0], want.word);
				if (m_tdata[34:32] !== want.index)
					report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(want.index));
				if (m_tlast !== want.is_last)
					report_mismatch("last_word", 32'(m_tlast), 32'(want.is_last));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int sent;
		int msgs;
		int len;
		int pick;
		bit byte_closes;
		msg_item_t row;
		sent = 0;
		msgs = 0;
		hash_restart();
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;
		steady   <= 1'b0;
		arst_n   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ITEMS[i]) begin
			row = DIRECTED_ITEMS[i];
			send_item(row.data, row.present, row.eom, row.typed, row.digest);
		end
		hold_until_drained();

		while (sent < 200) begin
			// one long message runs with both sides streaming flat out
			steady <= (msgs == 1);
			pick = $urandom_range(99);
			if (pick < 55)
				len = $urandom_range(12);
			else if (pick < 85)
				len = BOUNDARY_LENS[$urandom_range(7)];
			else
				len = $urandom_range(130, 13);
			if (msgs == 1)
				len = STEADY_LEN;
			byte_closes = (len > 0) && ($urandom_range(1) == 1);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 8) begin
					send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
					sent++;
				end
				send_item(8'($urandom_range(255)), 1'b1, byte_closes && (k == len - 1),
					1'b0, '0);
				sent++;
			end
			if (!byte_closes) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
				sent++;
			end
			msgs++;
			if ($urandom_range(99) < 20)
				hold_until_drained();
		end

		s_tvalid <= 1'b0;
		steady   <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hdl/shamh_pkg.sv
hdl/shamh_round.sv
hdl/sha256_message_hasher_core.sv
tb/sha256_message_hasher_core_tb.sv
